[hw/rtl/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
`default_nettype none

package deq_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Widths fixed by the interface.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/deq_mem.sv]
// Entry store: single-port-write, single-read memory with registered read data.
`default_nettype none

module deq_mem #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    output logic      [deq_pkg::VALUE_W-1:0]  o_rd_data
);

    logic [deq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/deq_ctrl.sv]
// Index, count and sequencing logic of the queue, with the result register.
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] i_push_value,
    // Result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [deq_pkg::VALUE_W-1:0]      o_pop_value,
    output logic [1:0]                              o_status,
    output logic [deq_pkg::COUNT_W-1:0]             o_item_count,
    output logic                                    o_is_empty_flag,
    // Memory side
    output logic                                    o_wr_en,
    output logic [AW-1:0]                           o_wr_addr,
    output logic [deq_pkg::VALUE_W-1:0]             o_wr_data,
    output logic                                    o_rd_en,
    output logic [AW-1:0]                           o_rd_addr,
    input  wire logic [deq_pkg::VALUE_W-1:0]        i_rd_data,
    // Observation
    output logic                                    o_busy,
    output logic [CW-1:0]                           o_count
);

    localparam int EW = CW + deq_pkg::COUNT_W;

    deq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;

    logic                               r_out_valid, n_out_valid;
    logic [deq_pkg::VALUE_W-1:0]        r_pop_value, n_pop_value;
    logic [1:0]                         r_status, n_status;
    logic [deq_pkg::COUNT_W-1:0]        r_item_count, n_item_count;
    logic                               r_empty_flag, n_empty_flag;

    logic          w_out_free;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic          w_go_read;
    logic [1:0]    w_req_status;
    logic [AW-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic [EW-1:0] w_count_ext;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == deq_pkg::S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_tail_inc = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign w_tail_dec = (r_tail == '0) ? AW'(DEPTH - 1) : r_tail - AW'(1);

    // Request decode: pointers and count move at the accept edge; a pop then
    // waits in the read state for the store's registered read data.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        w_req_status = deq_pkg::ST_OK;
        w_go_read    = 1'b0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_tail;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_head;
        case (i_opcode)
            deq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_req_status = deq_pkg::ST_FULL;
                end else begin
                    n_head    = w_head_dec;
                    n_count   = r_count + CW'(1);
                    o_wr_en   = w_accept;
                    o_wr_addr = w_head_dec;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_req_status = deq_pkg::ST_FULL;
                end else begin
                    n_tail    = w_tail_inc;
                    n_count   = r_count + CW'(1);
                    o_wr_en   = w_accept;
                    o_wr_addr = r_tail;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_req_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_head    = w_head_inc;
                    n_count   = r_count - CW'(1);
                    w_go_read = 1'b1;
                    o_rd_en   = w_accept;
                    o_rd_addr = r_head;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_req_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_tail    = w_tail_dec;
                    n_count   = r_count - CW'(1);
                    w_go_read = 1'b1;
                    o_rd_en   = w_accept;
                    o_rd_addr = w_tail_dec;
                end
            end
            default: begin
                w_req_status = deq_pkg::ST_OK;
            end
        endcase
    end

    assign o_wr_data   = i_push_value;
    assign w_count_ext = EW'(n_count);

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_pop_value  = r_pop_value;
        n_status     = r_status;
        n_item_count = r_item_count;
        n_empty_flag = r_empty_flag;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_go_read) begin
                        n_state      = deq_pkg::S_READ;
                        n_item_count = w_count_ext[deq_pkg::COUNT_W-1:0];
                        n_empty_flag = (n_count == '0);
                    end else begin
                        n_out_valid  = 1'b1;
                        n_pop_value  = '0;
                        n_status     = w_req_status;
                        n_item_count = w_count_ext[deq_pkg::COUNT_W-1:0];
                        n_empty_flag = (n_count == '0);
                    end
                end
            end
            deq_pkg::S_READ: begin
                // The result register was freed at the accept edge, so it can
                // always take the read data now.
                n_state     = deq_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_pop_value = i_rd_data;
                n_status    = deq_pkg::ST_OK;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_value  <= n_pop_value;
        r_status     <= n_status;
        r_item_count <= n_item_count;
        r_empty_flag <= n_empty_flag;
    end

    assign o_out_valid     = r_out_valid;
    assign o_pop_value     = r_pop_value;
    assign o_status        = r_status;
    assign o_item_count    = r_item_count;
    assign o_is_empty_flag = r_empty_flag;
    assign o_busy          = (r_state == deq_pkg::S_READ);
    assign o_count         = r_count;

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values in a circular memory.
// A push or a failed pop has its result in the output register in the cycle after
// acceptance; a successful pop first passes through the memory read register.
// Pushes: one item every cycle unless results stall; a pop stalls input until its read ends.
// Reset clears head, tail, count and the sequencer; the entry memory is not cleared.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] i_push_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [deq_pkg::VALUE_W-1:0]      o_pop_value,
    output logic [1:0]                              o_status,
    output logic [deq_pkg::COUNT_W-1:0]             o_item_count,
    output logic                                    o_is_empty_flag
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [deq_pkg::VALUE_W-1:0]  w_wr_data;
    logic                         w_rd_en;
    logic [AW-1:0]                w_rd_addr;
    logic [deq_pkg::VALUE_W-1:0]  w_rd_data;
    logic                         w_busy;
    logic [CW-1:0]                w_count;
    logic                         w_in_accept;

    deq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pop_value    (o_pop_value),
        .o_status       (o_status),
        .o_item_count   (o_item_count),
        .o_is_empty_flag(o_is_empty_flag),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_busy         (w_busy),
        .o_count        (w_count)
    );

    deq_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_in_accept = i_in_valid && !o_in_stall;

    // The count never goes past the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(DEPTH))
        else $error("queue count exceeds capacity");

    // Every accepted item either has its result registered or is reading memory.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (o_out_valid || w_busy))
        else $error("accepted item produced neither result nor read");

    // While a pop read is in flight the result register is free.
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_out_valid)
        else $error("result register occupied during pop read");

    // A pop read always completes into the result register at the next clock edge.
    a_read_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |=> (o_out_valid && !w_busy))
        else $error("pop read did not complete");

endmodule

`default_nettype wire
